### hw/rtl/moving_obstacle_segment_detector_defines.svh
// ----------------------------------------------------------------------------
// Moving obstacle segment detector: assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and held off by
// rst_ni. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef MOVING_OBSTACLE_SEGMENT_DETECTOR_DEFINES_SVH
`define MOVING_OBSTACLE_SEGMENT_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MOSD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mosd assertion failed");

// next-cycle implication
`define MOSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mosd assertion failed");

`else

`define MOSD_ASSERT_SAME(lbl, ante, cons)
`define MOSD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### hw/rtl/mosd_pkg.sv
// ----------------------------------------------------------------------------
// Moving obstacle segment detector package
// Register indices, configuration record and reset values.
// ----------------------------------------------------------------------------
package mosd_pkg;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned GroupW   = 8;
  localparam int unsigned ThrW     = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE         = 3'd0,
    CFG_GROUP_SIZE     = 3'd1,
    CFG_MIN_Y_EXTENT   = 3'd2,
    CFG_MAX_Y_EXTENT   = 3'd3,
    CFG_X_SPAN_MAX     = 3'd4,
    CFG_MIN_X_DISTANCE = 3'd5,
    CFG_MIN_STEP       = 3'd6,
    CFG_MAX_STEP       = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic              enable;
    logic [GroupW-1:0] group_size;
    logic [ThrW-1:0]   min_y_extent;
    logic [ThrW-1:0]   max_y_extent;
    logic [ThrW-1:0]   x_span_max;
    logic [ThrW-1:0]   min_x_distance;
    logic [ThrW-1:0]   min_step;
    logic [ThrW-1:0]   max_step;
  } cfg_t;

  localparam logic [GroupW-1:0] GroupSizeRst = 8'd5;
  localparam logic [GroupW-1:0] GroupSizeMin = 8'd2;
  localparam logic [ThrW-1:0]   ThrLowRst    = 16'h0000;
  localparam logic [ThrW-1:0]   ThrHighRst   = 16'hFFFF;

endpackage

### hw/rtl/mosd_if.sv
// ----------------------------------------------------------------------------
// Moving obstacle segment detector channels
// Segment input channel and verdict output channel, valid/ready.
// ----------------------------------------------------------------------------
interface mosd_seg_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] last_x;
  logic signed [COORD_WIDTH-1:0] last_y;
  logic                          end_of_frame;

  modport source (output valid, first_x, first_y, last_x, last_y, end_of_frame,
                  input ready);
  modport sink (input valid, first_x, first_y, last_x, last_y, end_of_frame,
                output ready);
endinterface

interface mosd_res_if;
  logic valid;
  logic ready;
  logic moving_obstacle;

  modport source (output valid, moving_obstacle, input ready);
  modport sink (input valid, moving_obstacle, output ready);
endinterface

### hw/rtl/mosd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register file for the detector thresholds and controls.
// ----------------------------------------------------------------------------
module mosd_cfg_regs
  import mosd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_ENABLE:         cfg_d.enable         = cfg_wdata_i[0];
        CFG_GROUP_SIZE:     cfg_d.group_size     = cfg_wdata_i[GroupW-1:0];
        CFG_MIN_Y_EXTENT:   cfg_d.min_y_extent   = cfg_wdata_i[ThrW-1:0];
        CFG_MAX_Y_EXTENT:   cfg_d.max_y_extent   = cfg_wdata_i[ThrW-1:0];
        CFG_X_SPAN_MAX:     cfg_d.x_span_max     = cfg_wdata_i[ThrW-1:0];
        CFG_MIN_X_DISTANCE: cfg_d.min_x_distance = cfg_wdata_i[ThrW-1:0];
        CFG_MIN_STEP:       cfg_d.min_step       = cfg_wdata_i[ThrW-1:0];
        CFG_MAX_STEP:       cfg_d.max_step       = cfg_wdata_i[ThrW-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable         <= 1'b0;
      cfg_q.group_size     <= GroupSizeRst;
      cfg_q.min_y_extent   <= ThrLowRst;
      cfg_q.max_y_extent   <= ThrHighRst;
      cfg_q.x_span_max     <= ThrHighRst;
      cfg_q.min_x_distance <= ThrLowRst;
      cfg_q.min_step       <= ThrLowRst;
      cfg_q.max_step       <= ThrHighRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/mosd_seg_filter.sv
// ----------------------------------------------------------------------------
// Segment window filter
// Strict window tests on y extent, x width and x distance of both ends.
// ----------------------------------------------------------------------------
module mosd_seg_filter
  import mosd_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  cfg_t                          cfg_i,
  input  logic signed [COORD_WIDTH-1:0] first_x_i,
  input  logic signed [COORD_WIDTH-1:0] first_y_i,
  input  logic signed [COORD_WIDTH-1:0] last_x_i,
  input  logic signed [COORD_WIDTH-1:0] last_y_i,
  output logic                          keep_o
);

  localparam int ExtW = COORD_WIDTH + 1;
  localparam int CmpW = (ExtW > ThrW + 1) ? ExtW : ThrW + 1;

  logic [ExtW-1:0] ey_diff, wx_diff, ey_abs, wx_abs;
  logic [ExtW-1:0] fx_ext, lx_ext, fx_abs, lx_abs;

  // widen by one bit so differences and magnitudes cannot overflow
  assign ey_diff = {first_y_i[COORD_WIDTH-1], first_y_i} - {last_y_i[COORD_WIDTH-1], last_y_i};
  assign wx_diff = {first_x_i[COORD_WIDTH-1], first_x_i} - {last_x_i[COORD_WIDTH-1], last_x_i};
  assign fx_ext  = {first_x_i[COORD_WIDTH-1], first_x_i};
  assign lx_ext  = {last_x_i[COORD_WIDTH-1], last_x_i};

  assign ey_abs = ey_diff[ExtW-1] ? (~ey_diff + 1'b1) : ey_diff;
  assign wx_abs = wx_diff[ExtW-1] ? (~wx_diff + 1'b1) : wx_diff;
  assign fx_abs = fx_ext[ExtW-1]  ? (~fx_ext + 1'b1)  : fx_ext;
  assign lx_abs = lx_ext[ExtW-1]  ? (~lx_ext + 1'b1)  : lx_ext;

  assign keep_o = (CmpW'(ey_abs) > CmpW'(cfg_i.min_y_extent)) &&
                  (CmpW'(ey_abs) < CmpW'(cfg_i.max_y_extent)) &&
                  (CmpW'(wx_abs) < CmpW'(cfg_i.x_span_max)) &&
                  (CmpW'(fx_abs) > CmpW'(cfg_i.min_x_distance)) &&
                  (CmpW'(lx_abs) > CmpW'(cfg_i.min_x_distance));

endmodule

### hw/rtl/mosd_group_tracker.sv
// ----------------------------------------------------------------------------
// Group tracker
// Counts kept samples, checks y steps and folds group verdicts into the
// frame verdict.
// ----------------------------------------------------------------------------
`include "moving_obstacle_segment_detector_defines.svh"

module mosd_group_tracker
  import mosd_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  logic                          fire_i,
  input  logic                          keep_i,
  input  logic signed [COORD_WIDTH-1:0] first_y_i,
  input  logic                          eof_i,
  output logic                          emit_o,
  output logic                          verdict_o
);

  localparam int ExtW = COORD_WIDTH + 1;
  localparam int CmpW = (ExtW > ThrW + 1) ? ExtW : ThrW + 1;

  logic [GroupW-1:0]      kept_count_q, kept_count_d;
  logic [COORD_WIDTH-1:0] prev_y_q, prev_y_d;
  logic                   steps_ok_q, steps_ok_d;
  logic                   verdict_q, verdict_d;

  logic                   active;
  logic [ExtW-1:0]        step_diff, step_abs;
  logic                   step_ok, steps_now, verdict_now;
  logic [GroupW-1:0]      need, count_inc;

  assign active    = fire_i && cfg_i.enable;
  assign step_diff = {first_y_i[COORD_WIDTH-1], first_y_i} - {prev_y_q[COORD_WIDTH-1], prev_y_q};
  assign step_abs  = step_diff[ExtW-1] ? (~step_diff + 1'b1) : step_diff;
  assign step_ok   = (CmpW'(step_abs) > CmpW'(cfg_i.min_step)) &&
                     (CmpW'(step_abs) < CmpW'(cfg_i.max_step));
  assign need      = (cfg_i.group_size < GroupSizeMin) ? GroupSizeMin : cfg_i.group_size;
  assign count_inc = kept_count_q + 1'b1;
  // first sample of a group has no step to judge
  assign steps_now = (kept_count_q == '0) ? 1'b1 : (steps_ok_q && step_ok);

  always_comb begin
    kept_count_d = kept_count_q;
    prev_y_d     = prev_y_q;
    steps_ok_d   = steps_ok_q;
    verdict_now  = verdict_q;
    if (active && keep_i) begin
      prev_y_d = first_y_i;
      if (count_inc >= need) begin
        // group complete: fold its verdict and start afresh
        verdict_now  = verdict_q || steps_now;
        kept_count_d = '0;
        steps_ok_d   = 1'b1;
      end else begin
        kept_count_d = count_inc;
        steps_ok_d   = steps_now;
      end
    end
    verdict_d = (active && eof_i) ? 1'b0 : verdict_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_count_q <= '0;
      prev_y_q     <= '0;
      steps_ok_q   <= 1'b1;
      verdict_q    <= 1'b0;
    end else begin
      kept_count_q <= kept_count_d;
      prev_y_q     <= prev_y_d;
      steps_ok_q   <= steps_ok_d;
      verdict_q    <= verdict_d;
    end
  end

  assign emit_o    = cfg_i.enable && eof_i;
  assign verdict_o = verdict_now;

  `MOSD_ASSERT_NEXT(a_disabled_frozen, !cfg_i.enable, $stable(kept_count_q) && $stable(verdict_q) && $stable(steps_ok_q))
  `MOSD_ASSERT_NEXT(a_eof_clears_verdict, active && eof_i, !verdict_q)
  `MOSD_ASSERT_NEXT(a_group_start_clean, active && keep_i && kept_count_q == '0, steps_ok_q)

endmodule

### hw/rtl/moving_obstacle_segment_detector.sv
// ----------------------------------------------------------------------------
// Moving obstacle segment detector
// Window-filters lidar segments, tracks groups of kept samples and reports
// one moving-obstacle verdict per frame.
// ----------------------------------------------------------------------------
// Takes one segment word per clock when not stalled and gives one verdict
// word for each end-of-frame segment while enabled. A segment is latched in
// the input register, then filtered and folded into the group state as it
// advances, and an end-of-frame verdict lands in the result register at that
// same moment. The rate is set by the group-state update (one y subtract and
// two compares against the previous kept y). Input is stalled only while a
// verdict sits unread in the result register and the latched segment ends
// a frame while enabled. The user is to write thresholds through the plain
// write port while the block is idle; the block does not enforce this.
`include "moving_obstacle_segment_detector_defines.svh"

module moving_obstacle_segment_detector
  import mosd_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  mosd_seg_if.sink            seg_in,
  mosd_res_if.source          res_out,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t cfg;

  logic                          s1_valid_q;
  logic signed [COORD_WIDTH-1:0] s1_fx_q, s1_fy_q, s1_lx_q, s1_ly_q;
  logic                          s1_eof_q;
  logic                          s1_adv, in_fire;
  logic                          keep, tr_emit, tr_verdict;
  logic                          res_valid_q, res_q;

  mosd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // advance unless a verdict would land on an unread one
  assign s1_adv       = s1_valid_q && (!tr_emit || !res_valid_q || res_out.ready);
  assign seg_in.ready = !s1_valid_q || s1_adv;
  assign in_fire      = seg_in.valid && seg_in.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (seg_in.ready) begin
      s1_valid_q <= seg_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_fx_q  <= seg_in.first_x;
      s1_fy_q  <= seg_in.first_y;
      s1_lx_q  <= seg_in.last_x;
      s1_ly_q  <= seg_in.last_y;
      s1_eof_q <= seg_in.end_of_frame;
    end
  end

  mosd_seg_filter #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_filter (
    .cfg_i     (cfg),
    .first_x_i (s1_fx_q),
    .first_y_i (s1_fy_q),
    .last_x_i  (s1_lx_q),
    .last_y_i  (s1_ly_q),
    .keep_o    (keep)
  );

  mosd_group_tracker #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .fire_i    (s1_adv),
    .keep_i    (keep),
    .first_y_i (s1_fy_q),
    .eof_i     (s1_eof_q),
    .emit_o    (tr_emit),
    .verdict_o (tr_verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_adv && tr_emit) begin
      res_valid_q <= 1'b1;
    end else if (res_out.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && tr_emit) begin
      res_q <= tr_verdict;
    end
  end

  assign res_out.valid           = res_valid_q;
  assign res_out.moving_obstacle = res_q;

  `MOSD_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_fy_q) && $stable(s1_eof_q))
  `MOSD_ASSERT_SAME(a_no_res_overwrite, res_valid_q && !res_out.ready, !(s1_adv && tr_emit))
  `MOSD_ASSERT_NEXT(a_res_from_eof, !res_valid_q, !res_valid_q || $past(s1_adv && tr_emit))

endmodule
